@@ rtl/stq_pkg.sv @@
package stq_pkg;

  localparam int REQ_W    = 2;
  localparam int SEC_W    = 16;
  localparam int USEC_W   = 20;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;
  // seconds times one million plus microseconds always fits here
  localparam int PROD_W   = 36;
  localparam int unsigned USEC_PER_SEC = 1000000;

  typedef enum logic [REQ_W-1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_POLL     = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_SCHEDULED = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EXPIRED   = 3'd4,
    STAT_NONE_DUE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_MATCH,
    CELL_REMOVE,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FULL,
    S_MUL,
    S_ADD,
    S_INSERT,
    S_MATCH,
    S_REMOVE,
    S_POLL
  } state_t;

endpackage

@@ rtl/stq_cell.sv @@
module stq_cell #(
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  stq_pkg::cell_ctrl_t  ctrl,
  input  logic                 occ,
  input  logic                 at_tail,
  input  logic                 left_gt,
  input  logic                 left_hit,
  input  logic [TIME_BITS-1:0] new_dl,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TIME_BITS-1:0] left_dl,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [TIME_BITS-1:0] right_dl,
  input  logic [ID_BITS-1:0]   right_id,
  output logic [TIME_BITS-1:0] dl,
  output logic [ID_BITS-1:0]   id,
  output logic                 gt,
  output logic                 hit
);
  import stq_pkg::*;

  logic match_q;

  assign gt  = occ && (dl > new_dl);
  // first match wins: every cell from the match onward pulls from the right
  assign hit = left_hit || match_q;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_MATCH: begin
        match_q <= occ && (id == new_id);
      end
      CELL_INSERT: begin
        if (left_gt) begin
          dl <= left_dl;
          id <= left_id;
        end else if (gt || at_tail) begin
          dl <= new_dl;
          id <= new_id;
        end
      end
      CELL_REMOVE: begin
        if (hit) begin
          dl <= right_dl;
          id <= right_id;
        end
      end
      CELL_POP: begin
        dl <= right_dl;
        id <= right_id;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/stq_ctrl.sv @@
module stq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int TIME_BITS   = 48,
  parameter int COUNT_W     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stq_pkg::REQ_W-1:0]    req_type,
  input  logic [ID_BITS-1:0]           timer_id,
  input  logic [stq_pkg::SEC_W-1:0]    delay_sec,
  input  logic [stq_pkg::USEC_W-1:0]   delay_usec,
  input  logic [TIME_BITS-1:0]         now_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stq_pkg::STATUS_W-1:0] status,
  output logic [ID_BITS-1:0]           expired_id,
  output logic                         last_of_run,
  output logic [stq_pkg::OCC_W-1:0]    occupancy,
  output stq_pkg::cell_ctrl_t          cell_ctrl,
  output logic [COUNT_W-1:0]           count,
  output logic [TIME_BITS-1:0]         new_dl,
  output logic [ID_BITS-1:0]           new_id,
  input  logic [TIME_BITS-1:0]         head_dl,
  input  logic [ID_BITS-1:0]           head_id,
  input  logic [TIME_BITS-1:0]         next_dl,
  input  logic                         any_hit
);
  import stq_pkg::*;

  localparam int SUM_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count_next;
  logic [SEC_W-1:0]     sec_q;
  logic [USEC_W-1:0]    usec_q;
  logic [TIME_BITS-1:0] now_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SUM_W-1:0]     sum;
  logic                 out_free;
  logic                 emit;
  status_t              emit_status;
  logic [ID_BITS-1:0]   emit_id;
  logic                 emit_last;
  logic                 due_head, due_next;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign sum = SUM_W'(now_q) + SUM_W'(prod_q) + SUM_W'(usec_q);
  assign due_head = (count != '0) && (head_dl <= now_q);
  assign due_next = (count > COUNT_W'(1)) && (next_dl <= now_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sec_q  <= delay_sec;
      usec_q <= delay_usec;
      now_q  <= now_time;
      new_id <= timer_id;
    end
    if (state == S_MUL) begin
      prod_q <= PROD_W'(sec_q) * PROD_W'(USEC_PER_SEC);
    end
    if (state == S_ADD) begin
      // saturate a deadline past the top of the time range
      if ((sum >> TIME_BITS) != '0) begin
        new_dl <= '1;
      end else begin
        new_dl <= TIME_BITS'(sum);
      end
    end
    if (emit) begin
      status      <= emit_status;
      expired_id  <= emit_id;
      last_of_run <= emit_last;
      occupancy   <= OCC_W'(32'(count_next));
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    cell_ctrl.op = CELL_HOLD;
    emit         = 1'b0;
    emit_status  = STAT_SCHEDULED;
    emit_id      = '0;
    emit_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_SCHEDULE: begin
              state_next = (count == COUNT_W'(QUEUE_DEPTH)) ? S_FULL : S_MUL;
            end
            REQ_CANCEL: state_next = S_MATCH;
            REQ_POLL:   state_next = S_POLL;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_FULL: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = STAT_FULL;
          state_next  = S_IDLE;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_INSERT;
      S_INSERT: begin
        if (out_free) begin
          cell_ctrl.op = CELL_INSERT;
          count_next   = count + COUNT_W'(1);
          emit         = 1'b1;
          emit_status  = STAT_SCHEDULED;
          state_next   = S_IDLE;
        end
      end
      S_MATCH: begin
        cell_ctrl.op = CELL_MATCH;
        state_next   = S_REMOVE;
      end
      S_REMOVE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (any_hit) begin
            cell_ctrl.op = CELL_REMOVE;
            count_next   = count - COUNT_W'(1);
            emit_status  = STAT_CANCELLED;
          end else begin
            emit_status = STAT_NOT_FOUND;
          end
        end
      end
      S_POLL: begin
        if (out_free) begin
          emit = 1'b1;
          if (due_head) begin
            // pop the head; stay while the entry behind it is due too
            cell_ctrl.op = CELL_POP;
            count_next   = count - COUNT_W'(1);
            emit_status  = STAT_EXPIRED;
            emit_id      = head_id;
            emit_last    = !due_next;
            state_next   = due_next ? S_POLL : S_IDLE;
          end else begin
            emit_status = STAT_NONE_DUE;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/sorted_timer_queue.sv @@
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   req_type, timer_id, delay_sec, delay_usec, now_time
// out      output     out_valid / out_ready status, expired_id, last_of_run, occupancy
//
// Schedule runs multiply, add, then one shift of the cell chain; a full queue skips them.
// Cancel: match in every cell, then one shift if a cell matched. Poll gives one result
// per expired entry, one pop of the chain per cycle while the output register is free.
// A new request is taken only once the previous one has placed its last result.
// Reset empties the queue at once; the cells themselves are not cleared.
// A held output register stalls the chain until the result is taken.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stq_pkg::REQ_W-1:0]    req_type,
  input  logic [ID_BITS-1:0]           timer_id,
  input  logic [stq_pkg::SEC_W-1:0]    delay_sec,
  input  logic [stq_pkg::USEC_W-1:0]   delay_usec,
  input  logic [TIME_BITS-1:0]         now_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stq_pkg::STATUS_W-1:0] status,
  output logic [ID_BITS-1:0]           expired_id,
  output logic                         last_of_run,
  output logic [stq_pkg::OCC_W-1:0]    occupancy
);
  import stq_pkg::*;

  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  cell_ctrl_t           cell_ctrl;
  logic [COUNT_W-1:0]   count;
  logic [TIME_BITS-1:0] new_dl;
  logic [ID_BITS-1:0]   new_id;
  logic [TIME_BITS-1:0] dl  [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   id  [QUEUE_DEPTH];
  logic                 gt  [QUEUE_DEPTH];
  logic                 hit [QUEUE_DEPTH];

  stq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_W    (COUNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .timer_id   (timer_id),
    .delay_sec  (delay_sec),
    .delay_usec (delay_usec),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .expired_id (expired_id),
    .last_of_run(last_of_run),
    .occupancy  (occupancy),
    .cell_ctrl  (cell_ctrl),
    .count      (count),
    .new_dl     (new_dl),
    .new_id     (new_id),
    .head_dl    (dl[0]),
    .head_id    (id[0]),
    .next_dl    (dl[1]),
    .any_hit    (hit[QUEUE_DEPTH-1])
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 left_gt, left_hit;
    logic [TIME_BITS-1:0] left_dl, right_dl;
    logic [ID_BITS-1:0]   left_id, right_id;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_hit = 1'b0;
      assign left_dl  = new_dl;
      assign left_id  = new_id;
    end else begin : g_inner
      assign left_gt  = gt[i-1];
      assign left_hit = hit[i-1];
      assign left_dl  = dl[i-1];
      assign left_id  = id[i-1];
    end

    // the last cell refills from itself; it leaves the valid range anyway
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_dl = dl[i];
      assign right_id = id[i];
    end else begin : g_mid
      assign right_dl = dl[i+1];
      assign right_id = id[i+1];
    end

    stq_cell #(
      .ID_BITS  (ID_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .occ     (COUNT_W'(i) < count),
      .at_tail (COUNT_W'(i) == count),
      .left_gt (left_gt),
      .left_hit(left_hit),
      .new_dl  (new_dl),
      .new_id  (new_id),
      .left_dl (left_dl),
      .left_id (left_id),
      .right_dl(right_dl),
      .right_id(right_id),
      .dl      (dl[i]),
      .id      (id[i]),
      .gt      (gt[i]),
      .hit     (hit[i])
    );
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import stq_pkg::*;

  localparam int DEPTH = 16;
  localparam int ID_W = 8;
  localparam int TIME_W = 48;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLDOFF_AFTER = 60;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_CYCLES = 30;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [ID_W-1:0]   id;
    logic [SEC_W-1:0]  dsec;
    logic [USEC_W-1:0] dusec;
    logic [TIME_W-1:0] now;
    bit                drain;
  } timer_req_t;

  typedef struct {
    status_t          stat;
    logic [ID_W-1:0]  id;
    logic             last;
    logic [OCC_W-1:0] occ;
  } timer_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type = REQ_SCHEDULE;
  logic [ID_W-1:0]     timer_id = '0;
  logic [SEC_W-1:0]    delay_sec = '0;
  logic [USEC_W-1:0]   delay_usec = '0;
  logic [TIME_W-1:0]   now_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     expired_id;
  logic                last_of_run;
  logic [OCC_W-1:0]    occupancy;

  sorted_timer_queue #(
    .QUEUE_DEPTH (DEPTH),
    .ID_BITS     (ID_W),
    .TIME_BITS   (TIME_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .timer_id    (timer_id),
    .delay_sec   (delay_sec),
    .delay_usec  (delay_usec),
    .now_time    (now_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .expired_id  (expired_id),
    .last_of_run (last_of_run),
    .occupancy   (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timer list as the block should hold it, earliest deadline in slot 0
  logic [TIME_W-1:0] sched_deadline [DEPTH];
  logic [ID_W-1:0]   sched_id [DEPTH];
  int                sched_count = 0;
  timer_result_t     expected_results [$];
  timer_req_t        req_items [$];

  int   next_idx = 0;
  int   mismatch_total = 0;
  int   checked_count = 0;
  logic results_idle = 1'b1;

  task automatic push_result(input status_t s, input logic [ID_W-1:0] id, input logic last);
    timer_result_t r;
    r.stat = s;
    r.id = id;
    r.last = last;
    r.occ = OCC_W'(sched_count);
    expected_results.push_back(r);
  endtask

  task automatic drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < sched_count; i++) begin
      sched_deadline[i] = sched_deadline[i + 1];
      sched_id[i] = sched_id[i + 1];
    end
    sched_count--;
  endtask

  task automatic apply_timer_request(input timer_req_t r);
    logic [63:0]     dl;
    logic [ID_W-1:0] popped;
    int              pos;
    int              i;
    bit              more;
    case (r.req)
      REQ_SCHEDULE: begin
        if (sched_count >= DEPTH) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          dl = 64'(r.now) + 64'(r.dsec) * USEC_PER_SEC + 64'(r.dusec);
          if (dl > 64'(TIME_MAX)) dl = 64'(TIME_MAX);
          pos = 0;
          while (pos < sched_count && 64'(sched_deadline[pos]) <= dl) pos++;
          for (i = sched_count; i > pos; i--) begin
            sched_deadline[i] = sched_deadline[i - 1];
            sched_id[i] = sched_id[i - 1];
          end
          sched_deadline[pos] = TIME_W'(dl);
          sched_id[pos] = r.id;
          sched_count++;
          push_result(STAT_SCHEDULED, '0, 1'b1);
        end
      end
      REQ_CANCEL: begin
        pos = 0;
        while (pos < sched_count && sched_id[pos] != r.id) pos++;
        if (pos < sched_count) begin
          drop_entry(pos);
          push_result(STAT_CANCELLED, '0, 1'b1);
        end else begin
          push_result(STAT_NOT_FOUND, '0, 1'b1);
        end
      end
      REQ_POLL: begin
        if (sched_count == 0 || sched_deadline[0] > r.now) begin
          push_result(STAT_NONE_DUE, '0, 1'b1);
        end else begin
          more = 1'b1;
          while (more) begin
            popped = sched_id[0];
            drop_entry(0);
            more = sched_count > 0 && sched_deadline[0] <= r.now;
            push_result(STAT_EXPIRED, popped, !more);
          end
        end
      end
      default: begin
        // unused request code: no result, list untouched
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at result %0d: %s got %0d want %0d", checked_count, field, got, want);
    mismatch_total++;
  endtask

  task automatic add_req(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                         input logic [SEC_W-1:0] dsec, input logic [USEC_W-1:0] dusec,
                         input logic [TIME_W-1:0] now, input bit drain);
    timer_req_t t;
    t.req = req;
    t.id = id;
    t.dsec = dsec;
    t.dusec = dusec;
    t.now = now;
    t.drain = drain;
    req_items.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin : driver
    bit just_sent;
    bit idle_roll;
    bit quiet;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      just_sent = in_valid && in_ready;
      if (just_sent) next_idx++;
      quiet = next_idx >= 90 && next_idx < 150;
      idle_roll = !quiet && $urandom_range(99) < 7;
      if (!in_valid || in_ready) begin
        // hold a drain item until results_idle reflects the last transfer
        if (next_idx < req_items.size() && !idle_roll &&
            !(req_items[next_idx].drain && (just_sent || !results_idle))) begin
          in_valid   <= 1'b1;
          req_type   <= req_items[next_idx].req;
          timer_id   <= req_items[next_idx].id;
          delay_sec  <= req_items[next_idx].dsec;
          delay_usec <= req_items[next_idx].dusec;
          now_time   <= req_items[next_idx].now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin : monitor
    timer_result_t want;
    timer_req_t    seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", status, 0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.stat) report_mismatch("status", status, want.stat);
          if (expired_id !== want.id) report_mismatch("expired_id", expired_id, want.id);
          if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
          if (occupancy !== want.occ) report_mismatch("occupancy", occupancy, want.occ);
        end
        checked_count++;
      end
      if (in_valid && in_ready) begin
        seen.req = req_type;
        seen.id = timer_id;
        seen.dsec = delay_sec;
        seen.dusec = delay_usec;
        seen.now = now_time;
        seen.drain = 1'b0;
        apply_timer_request(seen);
      end
      results_idle <= expected_results.size() == 0;
    end
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  always @(posedge clk) begin : receiver
    int accepted_in;
    int taken;
    int holdoff_left;
    if (rst) begin
      accepted_in = 0;
      taken = 0;
      holdoff_left = 0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_in++;
        if (accepted_in == HOLDOFF_AFTER) holdoff_left = HOLDOFF_CYCLES;
      end
      if (out_valid && out_ready) taken++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (taken >= 100 && taken < 160) || $urandom_range(99) >= 7;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    logic [63:0]       gen_now;
    logic [ID_W-1:0]   id;
    logic [SEC_W-1:0]  dsec;
    logic [USEC_W-1:0] dusec;
    logic [TIME_W-1:0] now;
    int                made;
    int                pick;
    int                k;

    // directed: empty poll, equal deadlines, ignored code, saturation, big usec, cancel hit and miss
    add_req(REQ_POLL, 8'h00, '0, '0, '0, 1'b0);
    add_req(REQ_SCHEDULE, 8'hFF, '0, '0, '0, 1'b0);
    add_req(REQ_SCHEDULE, 8'h11, '0, '0, '0, 1'b0);
    add_req(REQ_POLL, 8'h00, '0, '0, '0, 1'b0);
    add_req(REQ_UNUSED, 8'hFF, '1, '1, TIME_MAX, 1'b0);
    add_req(REQ_SCHEDULE, 8'hAA, '1, '1, TIME_MAX, 1'b0);
    add_req(REQ_SCHEDULE, 8'h55, 16'd1, '1, 48'd100, 1'b0);
    add_req(REQ_CANCEL, 8'h55, '0, '0, 48'd200, 1'b0);
    add_req(REQ_CANCEL, 8'h55, '0, '0, 48'd200, 1'b0);
    // fill to the limit with pairs of equal deadlines, overflow once, then drain all
    for (k = 0; k < DEPTH - 1; k++)
      add_req(REQ_SCHEDULE, ID_W'(8'h20 + k), '0, USEC_W'(k / 2), 48'd1000, 1'b0);
    add_req(REQ_SCHEDULE, 8'h77, '0, '0, 48'd1000, 1'b0);
    add_req(REQ_POLL, 8'h00, '0, '0, TIME_MAX, 1'b0);

    gen_now = 64'd2000;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      gen_now += ($urandom_range(99) < 5) ? $urandom_range(4000000) : $urandom_range(300000);
      pick = $urandom_range(99);
      id = ($urandom_range(99) < 80) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
      dsec = ($urandom_range(99) < 10) ? SEC_W'($urandom) : SEC_W'($urandom_range(1));
      dusec = ($urandom_range(99) < 5) ? USEC_W'($urandom) : USEC_W'($urandom_range(999999));
      now = ($urandom_range(99) < 4) ? TIME_W'({$urandom, $urandom}) : TIME_W'(gen_now);
      if (pick < 50) begin
        add_req(REQ_SCHEDULE, id, dsec, dusec, now, made == 0 || made == 150);
        made++;
      end else if (pick < 68) begin
        add_req(REQ_CANCEL, id, dsec, dusec, now, made == 0 || made == 150);
        made++;
      end else if (pick < 97) begin
        add_req(REQ_POLL, id, dsec, dusec, now, made == 0 || made == 150);
        made++;
      end else begin
        add_req(REQ_UNUSED, id, dsec, dusec, now, 1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (next_idx < req_items.size() || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
